// File: rtl/esc_pkg.sv
// Shared types and constants for the elevator scan controller.
package esc_pkg;

  localparam int FLOORS       = 4;
  localparam int FIDX_W       = $clog2(FLOORS);
  localparam int CALL_FLOOR_W = 4;
  localparam int CAR_FLOOR_W  = 5;
  localparam int EVENT_W      = 3;
  localparam int PEND_W       = 16;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_NOP,
    OP_CALL,
    OP_TICK
  } op_code_t;

  typedef struct packed {
    op_code_t          code;
    logic [FIDX_W-1:0] fidx;
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MOVE,
    PH_DOOR
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_WAIT,
    EV_UP,
    EV_DOWN,
    EV_OPEN,
    EV_CLOSE,
    EV_CALL
  } event_t;

endpackage

// File: rtl/esc_if.sv
// Handshake channels for command items and status results.
interface esc_item_if;
  import esc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [CALL_FLOOR_W-1:0] call_floor;

  modport source (output valid, output cmd, output call_floor, input ready);
  modport sink   (input valid, input cmd, input call_floor, output ready);
endinterface

interface esc_result_if;
  import esc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CAR_FLOOR_W-1:0] car_floor;
  logic                   going_up;
  logic [EVENT_W-1:0]     event_res;
  logic [PEND_W-1:0]      pending_calls;

  modport source (output valid, output car_floor, output going_up, output event_res,
                  output pending_calls, input ready);
  modport sink   (input valid, input car_floor, input going_up, input event_res,
                  input pending_calls, output ready);
endinterface

// File: rtl/esc_front.sv
// Front end: accepts command items and decodes them into queue operations.
module esc_front (
  esc_item_if.sink      item,
  input  logic          q_full,
  output logic          push,
  output esc_pkg::op_t  op
);
  import esc_pkg::*;

  logic in_range;

  assign item.ready = !q_full;
  assign push       = item.valid && !q_full;

  // Calls for floor 0 or above the top floor become no-ops.
  assign in_range = (item.call_floor != '0) &&
                    ({1'b0, item.call_floor} <= (CALL_FLOOR_W + 1)'(FLOORS));

  always_comb begin
    op.fidx = FIDX_W'(item.call_floor - CALL_FLOOR_W'(1));
    if (item.cmd) begin
      op.code = OP_TICK;
    end else if (in_range) begin
      op.code = OP_CALL;
    end else begin
      op.code = OP_NOP;
    end
  end

endmodule

// File: rtl/esc_fifo.sv
// Short operation queue between the front end and the car sequencer.
module esc_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  esc_pkg::op_t wr_op,
  input  logic         pop,
  output logic         full,
  output logic         rd_valid,
  output esc_pkg::op_t rd_op
);
  import esc_pkg::*;

  op_t               entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/esc_back.sv
// Back end: car state, scan target search and the registered result stage.
module esc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  esc_pkg::op_t  q_op,
  output logic          pop,
  esc_result_if.source  res
);
  import esc_pkg::*;

  logic [FIDX_W-1:0] pos;
  logic [FIDX_W-1:0] pos_next;
  logic              dir_up;
  logic              dir_up_next;
  logic [FLOORS-1:0] call_mask;
  logic [FLOORS-1:0] call_mask_next;
  logic [FIDX_W-1:0] target;
  logic [FIDX_W-1:0] target_next;
  phase_t            phase;
  phase_t            phase_next;
  event_t            ev;
  logic              out_valid;

  logic              above_hit;
  logic [FIDX_W-1:0] above_idx;
  logic              below_hit;
  logic [FIDX_W-1:0] below_idx;
  logic [FIDX_W-1:0] pos_up;
  logic [FIDX_W-1:0] pos_dn;

  assign pop       = q_valid && (!out_valid || res.ready);
  assign res.valid = out_valid;

  // Nearest call above: scan downward so the lowest qualifying floor wins.
  always_comb begin
    above_hit = 1'b0;
    above_idx = '0;
    for (int f = FLOORS - 1; f >= 0; f--) begin
      if (FIDX_W'(f) > pos && call_mask[f]) begin
        above_hit = 1'b1;
        above_idx = FIDX_W'(f);
      end
    end
  end

  // Nearest call below: scan upward so the highest qualifying floor wins.
  always_comb begin
    below_hit = 1'b0;
    below_idx = '0;
    for (int f = 0; f < FLOORS; f++) begin
      if (FIDX_W'(f) < pos && call_mask[f]) begin
        below_hit = 1'b1;
        below_idx = FIDX_W'(f);
      end
    end
  end

  assign pos_up = (pos == FIDX_W'(FLOORS - 1)) ? pos : pos + FIDX_W'(1);
  assign pos_dn = (pos == '0) ? pos : pos - FIDX_W'(1);

  always_comb begin
    pos_next       = pos;
    dir_up_next    = dir_up;
    call_mask_next = call_mask;
    target_next    = target;
    phase_next     = phase;
    ev             = EV_WAIT;
    case (q_op.code)
      OP_CALL: begin
        if (!call_mask[q_op.fidx]) begin
          call_mask_next[q_op.fidx] = 1'b1;
          ev = EV_CALL;
        end
      end
      OP_TICK: begin
        case (phase)
          PH_DOOR: begin
            call_mask_next[pos] = 1'b0;
            phase_next = PH_IDLE;
            ev = EV_CLOSE;
          end
          PH_MOVE: begin
            if (pos == target) begin
              phase_next = PH_DOOR;
              ev = EV_OPEN;
            end else if (dir_up) begin
              pos_next = pos_up;
              ev = EV_UP;
            end else begin
              pos_next = pos_dn;
              ev = EV_DOWN;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            if (call_mask[pos]) begin
              target_next = pos;
              phase_next = PH_DOOR;
              ev = EV_OPEN;
            end else if (dir_up && above_hit) begin
              target_next = above_idx;
              phase_next = PH_MOVE;
              pos_next = pos_up;
              ev = EV_UP;
            end else if (!dir_up && below_hit) begin
              target_next = below_idx;
              phase_next = PH_MOVE;
              pos_next = pos_dn;
              ev = EV_DOWN;
            end else if (dir_up && below_hit) begin
              // reverse toward the nearest call behind
              dir_up_next = 1'b0;
              target_next = below_idx;
              phase_next = PH_MOVE;
              pos_next = pos_dn;
              ev = EV_DOWN;
            end else if (!dir_up && above_hit) begin
              dir_up_next = 1'b1;
              target_next = above_idx;
              phase_next = PH_MOVE;
              pos_next = pos_up;
              ev = EV_UP;
            end
          end
        endcase
      end
      default: begin
        ev = EV_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      dir_up    <= 1'b1;
      call_mask <= '0;
      target    <= '0;
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        pos       <= pos_next;
        dir_up    <= dir_up_next;
        call_mask <= call_mask_next;
        target    <= target_next;
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: sampled after the update, held while stalled.
  always_ff @(posedge clk) begin
    if (pop) begin
      res.car_floor     <= CAR_FLOOR_W'(pos_next) + CAR_FLOOR_W'(1);
      res.going_up      <= dir_up_next;
      res.event_res     <= EVENT_W'(ev);
      res.pending_calls <= PEND_W'(call_mask_next);
    end
  end

endmodule

// File: rtl/elevator_scan_controller.sv
// Elevator scan controller: each accepted item waits in the queue, and its result goes
// valid from the result register once the sequencer pops the item.
// Throughput one item per cycle while results are taken; car state updates on each pop.
// A 2-entry queue separates decode from the sequencer; while a result stalls in the
// result register the queue takes up to two more items before input ready drops.
// Synchronous reset puts the car at floor 1, heading up, idle, with no calls pending.
module elevator_scan_controller (
  input  logic         clk,
  input  logic         rst,
  esc_item_if.sink     item,
  esc_result_if.source res
);
  import esc_pkg::*;

  logic q_full;
  logic push;
  op_t  wr_op;
  logic pop;
  logic q_valid;
  op_t  q_op;

  esc_front u_front (
    .item   (item),
    .q_full (q_full),
    .push   (push),
    .op     (wr_op)
  );

  esc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_op    (wr_op),
    .pop      (pop),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_op    (q_op)
  );

  esc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (pop),
    .res     (res)
  );

endmodule

// File: sim/esc_checker.sv
`timescale 1ns / 100ps
// Checker: predicts the status for each command transfer and compares every result.
module esc_checker (
  input  logic  clk,
  input  logic  rst,
  esc_item_if   item,
  esc_result_if res,
  output int    errors,
  output int    outstanding
);
  import esc_pkg::*;

  typedef struct packed {
    logic [CAR_FLOOR_W-1:0] car_floor;
    logic                   going_up;
    event_t                 event_res;
    logic [PEND_W-1:0]      pending_calls;
  } status_t;

  logic [3:0]        car_idx;
  logic [3:0]        target_idx;
  logic              heading_up;
  logic [PEND_W-1:0] calls;
  phase_t            phase;
  status_t           status_due[$];
  status_t           want;

  // Nearest call strictly above (up) or below (down) the car.
  function automatic logic nearest_call(input logic up, output logic [3:0] where);
    where = '0;
    if (up) begin
      for (int f = int'(car_idx) + 1; f < FLOORS; f++)
        if (calls[f]) begin
          where = 4'(f);
          return 1'b1;
        end
    end else begin
      for (int f = int'(car_idx) - 1; f >= 0; f--)
        if (calls[f]) begin
          where = 4'(f);
          return 1'b1;
        end
    end
    return 1'b0;
  endfunction

  function automatic event_t move_one();
    if (heading_up) begin
      if (int'(car_idx) + 1 < FLOORS) car_idx = car_idx + 4'd1;
      return EV_UP;
    end
    if (car_idx > 4'd0) car_idx = car_idx - 4'd1;
    return EV_DOWN;
  endfunction

  function automatic event_t tick_car();
    logic [3:0] t;
    logic       found;
    if (phase == PH_DOOR) begin
      calls[car_idx] = 1'b0;
      phase = PH_IDLE;
      return EV_CLOSE;
    end
    if (phase == PH_MOVE) begin
      if (car_idx == target_idx) begin
        phase = PH_DOOR;
        return EV_OPEN;
      end
      return move_one();
    end
    // idle, including the unused phase code
    phase = PH_IDLE;
    if (calls[car_idx]) begin
      target_idx = car_idx;
      phase = PH_DOOR;
      return EV_OPEN;
    end
    found = nearest_call(heading_up, t);
    if (!found) begin
      found = nearest_call(!heading_up, t);
      if (!found) return EV_WAIT;
      heading_up = !heading_up;
    end
    target_idx = t;
    phase = PH_MOVE;
    return move_one();
  endfunction

  function automatic status_t predict_status(input logic is_tick,
                                             input logic [CALL_FLOOR_W-1:0] floor_no);
    status_t s;
    event_t  ev;
    ev = EV_WAIT;
    if (!is_tick) begin
      if (floor_no >= 1 && floor_no <= FLOORS && !calls[floor_no - 1]) begin
        calls[floor_no - 1] = 1'b1;
        ev = EV_CALL;
      end
    end else begin
      ev = tick_car();
    end
    s.car_floor     = CAR_FLOOR_W'(car_idx) + 1'b1;
    s.going_up      = heading_up;
    s.event_res     = ev;
    s.pending_calls = calls;
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      car_idx    = '0;
      target_idx = '0;
      heading_up = 1'b1;
      calls      = '0;
      phase      = PH_IDLE;
      errors     = 0;
      status_due.delete();
    end else begin
      if (item.valid && item.ready)
        status_due.push_back(predict_status(item.cmd, item.call_floor));
      if (res.valid && res.ready) begin
        if (status_due.size() == 0) begin
          $error("status transfer with no command waiting for it");
          errors++;
        end else begin
          want = status_due.pop_front();
          check_field("car_floor", 32'(want.car_floor), 32'(res.car_floor));
          check_field("going_up", 32'(want.going_up), 32'(res.going_up));
          check_field("event_res", 32'(want.event_res), 32'(res.event_res));
          check_field("pending_calls", 32'(want.pending_calls), 32'(res.pending_calls));
        end
      end
    end
    outstanding = status_due.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top: drives calls and ticks into the elevator controller and gives the verdict.
module tb;
  import esc_pkg::*;

  typedef struct packed {
    logic                    is_tick;
    logic [CALL_FLOOR_W-1:0] floor_no;
  } req_t;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   due_count;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_left;
  int   hold_asks = 0;
  int   hold_seen = 0;

  // Calls, ticks, and the special cases of the scan order.
  req_t opening_run [25] = '{
    '{1'b1, 4'd0},  '{1'b0, 4'd0},  '{1'b0, 4'd15}, '{1'b0, 4'd5},  '{1'b0, 4'd1},
    '{1'b1, 4'd0},  '{1'b1, 4'd0},  '{1'b0, 4'd4},  '{1'b0, 4'd4},  '{1'b1, 4'd0},
    '{1'b0, 4'd2},  '{1'b1, 4'd0},  '{1'b1, 4'd0},  '{1'b1, 4'd0},  '{1'b1, 4'd0},
    '{1'b1, 4'd0},  '{1'b0, 4'd3},  '{1'b1, 4'd0},  '{1'b1, 4'd0},  '{1'b1, 4'd0},
    '{1'b0, 4'd1},  '{1'b1, 4'd15}, '{1'b1, 4'd0},  '{1'b1, 4'd0},  '{1'b0, 4'd8}
  };

  always #2 clk = ~clk;

  esc_item_if   item_ch ();
  esc_result_if res_ch ();

  elevator_scan_controller DUT (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .res  (res_ch)
  );

  esc_checker status_chk (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .res         (res_ch),
    .errors      (errors),
    .outstanding (due_count)
  );

  task automatic send(input logic is_tick, input logic [CALL_FLOOR_W-1:0] floor_no);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.cmd        <= is_tick;
    item_ch.call_floor <= floor_no;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
  endtask

  // Drop valid and hold until every status has come back.
  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    wait (due_count == 0);
  endtask

  task automatic run_phase(input int count, input int tx_pct, input int rx_pct);
    logic                    is_tick;
    logic [CALL_FLOOR_W-1:0] floor_no;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      is_tick  = ($urandom_range(0, 99) >= 35);
      floor_no = CALL_FLOOR_W'($urandom_range(0, 15));
      if (!is_tick && $urandom_range(0, 9) < 8)
        floor_no = CALL_FLOOR_W'($urandom_range(1, FLOORS));
      send(is_tick, floor_no);
      if (tx_pct == 0 && rx_pct == 0 && (i == 40 || i == 200))
        hold_asks++;
    end
  endtask

  initial begin
    res_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_left = 60;
        hold_seen = hold_asks;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    rst                = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.cmd        = 1'b0;
    item_ch.call_floor = '0;
    tx_idle_pct        = 17;
    rx_idle_pct        = 71;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_run[i]) send(opening_run[i].is_tick, opening_run[i].floor_no);
    drain();
    run_phase(300, 17, 71);
    drain();
    run_phase(300, 71, 17);
    drain();
    run_phase(300, 0, 0);
    drain();

    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("elevator_scan_controller test passed");
    else
      $display("elevator_scan_controller test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("elevator_scan_controller test failed");
    $finish;
  end

endmodule

// File: elevator_scan_controller.f
rtl/esc_pkg.sv
rtl/esc_if.sv
rtl/esc_front.sv
rtl/esc_fifo.sv
rtl/esc_back.sv
rtl/elevator_scan_controller.sv
sim/esc_checker.sv
sim/tb.sv
